@@ src/srfe_pkg.sv @@
// ----------------------------------------------------------------------------
// srfe_pkg: shared definitions for the square bit image rotate/flip engine
// Operation codes, field widths and default parameter values.
// ----------------------------------------------------------------------------
package srfe_pkg;

  localparam int OP_W    = 3;
  localparam int COORD_W = 6;
  localparam int SCALE_W = 4;

  localparam int IMAGE_SIZE_DEF = 8;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_ROT_CW = 3'd2;
  localparam logic [OP_W-1:0] OP_ROT_CC = 3'd3;
  localparam logic [OP_W-1:0] OP_FLIP_V = 3'd4;
  localparam logic [OP_W-1:0] OP_FLIP_H = 3'd5;
  localparam logic [OP_W-1:0] OP_SCALED = 3'd6;
  localparam logic [OP_W-1:0] OP_NONE   = 3'd7;

endpackage

@@ src/srfe_ram.sv @@
// ----------------------------------------------------------------------------
// srfe_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module srfe_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/srfe_div.sv @@
// ----------------------------------------------------------------------------
// srfe_div: iterative restoring divider
// Divides a coordinate by the scale factor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srfe_div
  import srfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] dividend,
  input  logic [SCALE_W-1:0] divisor,
  output logic               done,
  output logic [COORD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(COORD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(COORD_W - 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [COORD_W-1:0] q_r;
  logic [SCALE_W-1:0] rem_r;
  logic [SCALE_W-1:0] d_r;
  logic [SCALE_W:0]   trial;
  logic               fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_r, q_r[COORD_W-1]};
  assign fits  = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[COORD_W-2:0], fits};
      rem_r <= fits ? SCALE_W'(trial - {1'b0, d_r}) : trial[SCALE_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ src/square_bit_image_rotate_flip_engine.sv @@
// ----------------------------------------------------------------------------
// square_bit_image_rotate_flip_engine: one-bit square image store
// Pixel access, 90 degree rotations, flips and upscaled reads.
// ----------------------------------------------------------------------------
// Usage
//   A command transaction is taken when start is high and busy is low; the
//   fields in_op, in_row, in_col and in_pixel_in are sampled at that edge.
//   Every command gives exactly one result transaction: out_valid is high
//   for one cycle with out_pixel_out and out_of_range. The receiver cannot
//   stall the block, so the result is simply presented and gone.
//   The user writes the scale factor through cfg_we/cfg_data only while the
//   block is idle (not enforced by the block); a value of zero behaves as one.
// Command flow from start to out_valid (one command at a time)
//   write or op 7 : result from dispatch   read : after a registered RAM read
//   scaled read   : two passes through the bit-serial divider, then the RAM
//                   read; out-of-range reads of either kind skip the RAM read
//   rotate / flip : all IMAGE_SIZE*IMAGE_SIZE pixels go through the single
//                   RAM read port, which moves one pixel per cycle.
//   busy stays high from acceptance until the result is shown.
// Reset
//   The image reads as all zero after reset through per-entry valid bits;
//   no clearing pass is needed, so commands are taken at once.
// The image lives in two RAM banks. A transform reads the active bank and
// writes the remapped image into the other one, then swaps banks.
// ----------------------------------------------------------------------------
module square_bit_image_rotate_flip_engine
  import srfe_pkg::*;
#(
  parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_op,
  input  logic [COORD_W-1:0] in_row,
  input  logic [COORD_W-1:0] in_col,
  input  logic               in_pixel_in,
  output logic               out_valid,
  output logic               out_pixel_out,
  output logic               out_of_range,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_data
);

  localparam int DEPTH = IMAGE_SIZE * IMAGE_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(IMAGE_SIZE);
  localparam logic [RW-1:0]      NM1    = RW'(IMAGE_SIZE - 1);
  localparam logic [COORD_W-1:0] N_LIM  = COORD_W'(IMAGE_SIZE);

  // Sequencer state codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DIVR = 3'd3;
  localparam logic [2:0] S_DIVC = 3'd4;
  localparam logic [2:0] S_XF   = 3'd5;
  localparam logic [2:0] S_XFD  = 3'd6;

  function automatic logic [AW-1:0] lin_addr(input logic [RW-1:0] r,
                                             input logic [RW-1:0] c);
    return AW'(AW'(r) * AW'(IMAGE_SIZE)) + AW'(c);
  endfunction

  logic [2:0]         state_r, state_nxt;
  logic [SCALE_W-1:0] scale_r;
  logic [OP_W-1:0]    op_r;
  logic [COORD_W-1:0] row_r, col_r;
  logic               pin_r;
  logic [COORD_W-1:0] qrow_r;
  logic               sel_r;
  logic [DEPTH-1:0]   va_r, vb_r;
  logic [RW-1:0]      dr_r, dc_r;
  logic               pend_r;
  logic [AW-1:0]      wa_r;
  logic               rv_r;
  logic               ov_r, pix_r, oor_r;

  // Combinational control
  logic               ov_nxt, pix_nxt, oor_nxt;
  logic               host_we;
  logic [AW-1:0]      host_wa;
  logic [AW-1:0]      rd_addr;
  logic               xf_first, xf_step, xf_last;
  logic               div_start;
  logic [COORD_W-1:0] div_dividend;
  logic [SCALE_W-1:0] scale_eff;
  logic               div_done;
  logic [COORD_W-1:0] div_q;
  logic [RW-1:0]      src_r, src_c;
  logic               rdata_a, rdata_b, rdata_act;
  logic [DEPTH-1:0]   v_act;
  logic               we_a, we_b;
  logic [AW-1:0]      wa_a, wa_b;
  logic               wd_a, wd_b;
  logic               xf_wd;
  logic               in_rng, q_rng;

  assign busy      = (state_r != S_IDLE);
  assign scale_eff = (scale_r == '0) ? SCALE_W'(1) : scale_r;
  assign in_rng    = (row_r < N_LIM) && (col_r < N_LIM);
  assign q_rng     = (qrow_r < N_LIM) && (div_q < N_LIM);
  assign rdata_act = sel_r ? rdata_b : rdata_a;
  assign v_act     = sel_r ? vb_r : va_r;
  assign xf_wd     = rv_r & rdata_act;
  assign xf_last   = (dr_r == NM1) && (dc_r == NM1);

  // Source pixel for the destination (dr, dc) of the running transform.
  always_comb begin
    src_r = dr_r;
    src_c = dc_r;
    unique case (op_r)
      OP_ROT_CW: begin
        src_r = NM1 - dc_r;
        src_c = dr_r;
      end
      OP_ROT_CC: begin
        src_r = dc_r;
        src_c = NM1 - dr_r;
      end
      OP_FLIP_V: begin
        src_r = NM1 - dr_r;
      end
      OP_FLIP_H: begin
        src_c = NM1 - dc_r;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    ov_nxt       = 1'b0;
    pix_nxt      = 1'b0;
    oor_nxt      = 1'b0;
    host_we      = 1'b0;
    host_wa      = lin_addr(row_r[RW-1:0], col_r[RW-1:0]);
    rd_addr      = lin_addr(row_r[RW-1:0], col_r[RW-1:0]);
    xf_first     = 1'b0;
    xf_step      = 1'b0;
    div_start    = 1'b0;
    div_dividend = row_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (op_r)
          OP_WRITE: begin
            host_we   = in_rng;
            oor_nxt   = !in_rng;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_READ: begin
            if (in_rng) begin
              state_nxt = S_RD;
            end else begin
              oor_nxt   = 1'b1;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          OP_ROT_CW, OP_ROT_CC, OP_FLIP_V, OP_FLIP_H: begin
            xf_first  = 1'b1;
            state_nxt = S_XF;
          end
          OP_SCALED: begin
            div_start = 1'b1;
            state_nxt = S_DIVR;
          end
          default: begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RD: begin
        pix_nxt   = rv_r & rdata_act;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DIVR: begin
        div_dividend = col_r;
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = S_DIVC;
        end
      end
      S_DIVC: begin
        rd_addr = lin_addr(qrow_r[RW-1:0], div_q[RW-1:0]);
        if (div_done) begin
          if (q_rng) begin
            state_nxt = S_RD;
          end else begin
            oor_nxt   = 1'b1;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_XF: begin
        rd_addr = lin_addr(src_r, src_c);
        xf_step = 1'b1;
        if (xf_last) begin
          state_nxt = S_XFD;
        end
      end
      S_XFD: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Bank write steering: host writes go to the active bank, transform
  // writes to the other one.
  assign we_a = (host_we && !sel_r) || (pend_r && sel_r);
  assign we_b = (host_we && sel_r) || (pend_r && !sel_r);
  assign wa_a = sel_r ? wa_r : host_wa;
  assign wa_b = sel_r ? host_wa : wa_r;
  assign wd_a = sel_r ? xf_wd : pin_r;
  assign wd_b = sel_r ? pin_r : xf_wd;

  srfe_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_bank_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(wa_a),
    .wdata(wd_a),
    .raddr(rd_addr),
    .rdata(rdata_a)
  );

  srfe_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_bank_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(wa_b),
    .wdata(wd_b),
    .raddr(rd_addr),
    .rdata(rdata_b)
  );

  srfe_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (scale_eff),
    .done    (div_done),
    .quotient(div_q)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      scale_r <= SCALE_RESET;
      sel_r   <= 1'b0;
      va_r    <= '0;
      vb_r    <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= xf_step;
      if (cfg_we) begin
        scale_r <= cfg_data;
      end
      if (we_a) begin
        va_r[wa_a] <= 1'b1;
      end
      if (we_b) begin
        vb_r[wa_b] <= 1'b1;
      end
      if (state_r == S_XFD) begin
        sel_r <= !sel_r;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r  <= in_op;
      row_r <= in_row;
      col_r <= in_col;
      pin_r <= in_pixel_in;
    end
    if (state_r == S_DIVR && div_done) begin
      qrow_r <= div_q;
    end
    if (xf_first) begin
      dr_r <= '0;
      dc_r <= '0;
    end else if (xf_step) begin
      if (dc_r == NM1) begin
        dc_r <= '0;
        dr_r <= dr_r + RW'(1);
      end else begin
        dc_r <= dc_r + RW'(1);
      end
    end
    wa_r  <= lin_addr(dr_r, dc_r);
    rv_r  <= v_act[rd_addr];
    pix_r <= pix_nxt;
    oor_r <= oor_nxt;
  end

  assign out_valid     = ov_r;
  assign out_pixel_out = pix_r;
  assign out_of_range  = oor_r;

  // A result only follows a cycle in which a command was in progress.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r != S_IDLE))
    else $error("result strobe without a command in progress");

  // An out-of-range transaction never carries a pixel.
  a_oor_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_of_range) |-> !out_pixel_out)
    else $error("pixel returned with out_of_range");

  // The banks swap only at the end of a transform.
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(sel_r) |-> $past(state_r == S_XFD))
    else $error("bank select changed outside a transform");

  // Transform writes to the shadow bank stop before the result is shown.
  a_xf_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !pend_r)
    else $error("transform write still pending at result");

endmodule
